FILE: rtl/opmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical PWM / Manchester transmitter package
// Shared types and constants for the LED segment encoder.
// ----------------------------------------------------------------------------
package opmt_pkg;

	localparam int PERIOD_W = 22;
	localparam int DUR_W    = 22;
	localparam int BYTE_W   = 8;
	localparam int SEG_W    = 5;
	localparam int RECIP_W  = 20;
	localparam int Q_DEPTH  = 2;
	localparam int Q_AW     = 1;
	localparam int Q_CW     = 2;

	// floor(2^22 / 5); quotient estimate is low by at most one
	localparam logic [RECIP_W-1:0] RECIP5 = 20'd838860;

	localparam logic [SEG_W-1:0] SEG_LAST_BIT = 5'd15;
	localparam logic [SEG_W-1:0] SEG_IDLE     = 5'd16;

	localparam logic MODE_PULSE      = 1'b0;
	localparam logic MODE_MANCHESTER = 1'b1;

	typedef enum logic [1:0] {
		REG_PERIOD     = 2'd0,
		REG_DEFAULT_ON = 2'd1,
		REG_LED_SELECT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_us;
		logic                default_on;
		logic                led_select;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic led;
		logic level;
	} idle_drive_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              mode;
		logic              eom;
		logic              led;
		logic              lvl;
		logic              idle_lvl;
		logic [DUR_W-1:0]  t_short;
		logic [DUR_W-1:0]  t_long;
		logic [DUR_W-1:0]  t_half;
	} job_t;

endpackage

FILE: rtl/optical_pwm_manchester_tx_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical PWM / Manchester transmitter
// Turns bytes into timed LED pin segments in pulse-width or Manchester code.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         tdata[7:0] data_byte, tuser mode, tlast end_of_message
//  m_*       out        tdata pin_level, led_id, duration_us; tlast last
//  apb       in/out     0x0 period_us, 0x4 default_on, 0x8 led_select
//
//  Each byte yields 16 segments, 17 with end of message, one per cycle from
//  the segment sequencer while m_tready does not stall it. A byte passes the
//  front-end registers s1 and s2 before it is written to the queue, and its
//  segments leave through the sequencer's output register; the two-entry queue
//  lets the input take further bytes while the sequencer or m_tready stalls.
//  Reset is asynchronous: both pins idle high, registers take their defaults.
// ----------------------------------------------------------------------------
module optical_pwm_manchester_tx_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] mode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] pin_level, [1] led_id, [23:2] duration_us
	output logic        m_tlast
);
	import opmt_pkg::*;

	logic                wr;
	reg_idx_t            idx;
	logic [PERIOD_W-1:0] period_q;
	logic                default_on_q;
	logic                led_select_q;
	cfg_t                cfg;
	idle_drive_t         idle;
	logic                push;
	logic                full;
	logic                pop;
	logic                head_valid;
	job_t                job;
	job_t                head;
	logic                pin_level;
	logic                led_id;
	logic [DUR_W-1:0]    duration_us;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= 22'd66666;
			default_on_q <= 1'b0;
			led_select_q <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				REG_PERIOD:     period_q     <= pwdata[PERIOD_W-1:0];
				REG_DEFAULT_ON: default_on_q <= pwdata[0];
				REG_LED_SELECT: led_select_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PERIOD:     prdata = {{(32-PERIOD_W){1'b0}}, period_q};
			REG_DEFAULT_ON: prdata = {31'd0, default_on_q};
			REG_LED_SELECT: prdata = {31'd0, led_select_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.period_us  = period_q;
	assign cfg.default_on = default_on_q;
	assign cfg.led_select = led_select_q;

	assign idle.en    = wr && (idx == REG_DEFAULT_ON);
	assign idle.led   = led_select_q;
	assign idle.level = ~pwdata[0];

	opmt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.idle     (idle),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_mode  (s_tuser),
		.in_eom   (s_tlast),
		.full     (full),
		.push     (push),
		.job      (job)
	);

	opmt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	opmt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.pin_level   (pin_level),
		.led_id      (led_id),
		.duration_us (duration_us),
		.last        (m_tlast)
	);

	assign m_tdata = {duration_us, led_id, pin_level};

endmodule

FILE: rtl/opmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts bytes, tracks LED pin levels and derives the segment durations.
// ----------------------------------------------------------------------------
module opmt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  opmt_pkg::cfg_t               cfg,
	input  opmt_pkg::idle_drive_t        idle,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [opmt_pkg::BYTE_W-1:0]  in_byte,
	input  logic                         in_mode,
	input  logic                         in_eom,
	input  logic                         full,
	output logic                         push,
	output opmt_pkg::job_t               job
);
	import opmt_pkg::*;

	logic                        acc;
	logic                        adv1;
	logic                        ready_s2;
	logic [1:0]                  pin_q;
	logic                        v_s1;
	logic                        v_s2;
	job_t                        job_s1;
	job_t                        job_s2;
	logic [PERIOD_W-1:0]         period_s1;
	logic [PERIOD_W-1:0]         period_s2;
	logic [PERIOD_W+RECIP_W-1:0] prod;
	logic [RECIP_W-1:0]          q0_s2;
	logic [PERIOD_W-1:0]         five_q;
	logic [PERIOD_W-1:0]         diff;
	logic [3:0]                  r;
	logic                        ge;
	logic                        rem_nz;
	logic [DUR_W-1:0]            t_short;

	assign acc      = in_valid && in_ready;
	assign ready_s2 = !v_s2 || !full;
	assign adv1     = v_s1 && ready_s2;
	assign in_ready = !v_s1 || ready_s2;
	assign push     = v_s2 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q <= 2'b11;
		end else if (idle.en) begin
			pin_q[idle.led] <= idle.level;
		end else if (acc) begin
			if (in_eom) begin
				pin_q[cfg.led_select] <= ~cfg.default_on;
			end else if (in_mode == MODE_MANCHESTER) begin
				pin_q[cfg.led_select] <= ~in_byte[BYTE_W-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			job_s1.data_byte <= in_byte;
			job_s1.mode      <= in_mode;
			job_s1.eom       <= in_eom;
			job_s1.led       <= cfg.led_select;
			job_s1.lvl       <= pin_q[cfg.led_select];
			job_s1.idle_lvl  <= ~cfg.default_on;
			job_s1.t_short   <= '0;
			job_s1.t_long    <= '0;
			job_s1.t_half    <= '0;
			period_s1        <= cfg.period_us;
		end
		if (adv1) begin
			job_s2    <= job_s1;
			period_s2 <= period_s1;
			q0_s2     <= prod[PERIOD_W+RECIP_W-1:PERIOD_W];
		end
	end

	assign prod = period_s1 * RECIP5;

	// correct the quotient estimate by at most one
	always_comb begin
		five_q  = {q0_s2, 2'b00} + {2'b00, q0_s2};
		diff    = period_s2 - five_q;
		r       = diff[3:0];
		ge      = (r >= 4'd5);
		rem_nz  = ge ? (r != 4'd5) : (r != 4'd0);
		t_short = {2'b00, q0_s2} + {{(DUR_W-1){1'b0}}, ge};
		job         = job_s2;
		job.t_short = t_short;
		job.t_long  = period_s2 - t_short - {{(DUR_W-1){1'b0}}, rem_nz};
		job.t_half  = {1'b0, period_s2[PERIOD_W-1:1]};
	end

endmodule

FILE: rtl/opmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue between the front end and the segment sequencer.
// ----------------------------------------------------------------------------
module opmt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  opmt_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output opmt_pkg::job_t head
);
	import opmt_pkg::*;

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;

	assign full       = (cnt_q == Q_CW'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

endmodule

FILE: rtl/opmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment sequencer
// Expands one queued byte into its pin segments, one per cycle while out_ready does not stall it.
// ----------------------------------------------------------------------------
module opmt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  opmt_pkg::job_t              head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        pin_level,
	output logic                        led_id,
	output logic [opmt_pkg::DUR_W-1:0]  duration_us,
	output logic                        last
);
	import opmt_pkg::*;

	logic [SEG_W-1:0] cnt_q;
	logic             load;
	logic             fin;
	logic [2:0]       bit_i;
	logic             half;
	logic             pwm_bit;
	logic             man_bit;
	logic             seg_level;
	logic [DUR_W-1:0] seg_dur;
	logic             seg_last;
	logic             out_v_q;
	logic             pin_q;
	logic             led_q;
	logic [DUR_W-1:0] dur_q;
	logic             last_q;

	assign bit_i   = cnt_q[3:1];
	assign half    = cnt_q[0];
	assign pwm_bit = head.data_byte[3'd7 - bit_i];
	assign man_bit = head.data_byte[bit_i];
	assign fin     = head.eom ? (cnt_q == SEG_IDLE) : (cnt_q == SEG_LAST_BIT);
	assign load    = head_valid && (!out_v_q || out_ready);
	assign pop     = load && fin;

	always_comb begin
		seg_last = fin;
		if (cnt_q == SEG_IDLE) begin
			seg_level = head.idle_lvl;
			seg_dur   = '0;
		end else if (head.mode == MODE_MANCHESTER) begin
			seg_level = man_bit ^ half;
			seg_dur   = head.t_half;
		end else begin
			seg_level = head.lvl ^ ~half;
			seg_dur   = (pwm_bit ^ half) ? head.t_long : head.t_short;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q <= '0;
			end else if (load) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pin_q  <= seg_level;
			led_q  <= head.led;
			dur_q  <= seg_dur;
			last_q <= seg_last;
		end
	end

	assign out_valid   = out_v_q;
	assign pin_level   = pin_q;
	assign led_id      = led_q;
	assign duration_us = dur_q;
	assign last        = last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SEG_IDLE)
		else $error("segment counter out of range");

	a_idle_only_eom: assert property (@(posedge clk) disable iff (!arst_n)
		(load && cnt_q == SEG_IDLE) |-> head.eom)
		else $error("idle segment without end of message");

	a_pop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (cnt_q == '0))
		else $error("segment counter not rewound after pop");

endmodule

FILE: bench/optical_pwm_manchester_tx_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical PWM / Manchester transmitter checker
// Follows register writes and input beats, works out the pin segments each
// byte must produce, and matches every output beat against the oldest one
// still owed. Mismatches and unexpected beats add to the failure count.
// ----------------------------------------------------------------------------
module optical_pwm_manchester_tx_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] mode
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [0] pin_level, [1] led_id, [23:2] duration_us
	input  logic        m_tlast,
	output int          fails,
	output int          pending
);
	import opmt_pkg::*;

	typedef struct packed {
		logic             level;
		logic             led;
		logic [DUR_W-1:0] dur;
		logic             last;
	} segment_t;

	segment_t            seg_q[$];
	logic [PERIOD_W-1:0] period;
	logic                default_on;
	logic                led_sel;
	logic [1:0]          pin;

	function automatic void push_seg(logic level, logic [DUR_W-1:0] dur, logic last);
		segment_t s;
		s.level = level;
		s.led   = led_sel;
		s.dur   = dur;
		s.last  = last;
		seg_q.push_back(s);
	endfunction

	function automatic void encode_byte(logic [7:0] data, logic mode, logic eom);
		logic [31:0]      p;
		logic [DUR_W-1:0] t_short;
		logic [DUR_W-1:0] t_long;
		logic [DUR_W-1:0] t_half;
		logic             bitv;
		logic             lvl;
		logic             fin;
		p       = 32'(period);
		t_short = DUR_W'(p / 5);
		t_long  = DUR_W'((4 * p) / 5);
		t_half  = DUR_W'(p / 2);
		for (int i = 0; i < 8; i++) begin
			fin = (i == 7) && !eom;
			if (mode == MODE_MANCHESTER) begin
				bitv = data[i];
				push_seg(bitv, t_half, 1'b0);
				push_seg(~bitv, t_half, fin);
				pin[led_sel] = ~bitv;
			end else begin
				bitv = data[7 - i];
				lvl  = pin[led_sel];
				push_seg(~lvl, bitv ? t_long : t_short, 1'b0);
				push_seg(lvl, bitv ? t_short : t_long, fin);
			end
		end
		// restore idle level after the final byte
		if (eom) begin
			pin[led_sel] = ~default_on;
			push_seg(pin[led_sel], '0, 1'b1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		segment_t want;
		if (!arst_n) begin
			period     = 22'd66666;
			default_on = 1'b0;
			led_sel    = 1'b1;
			pin        = 2'b11;
			fails      = 0;
			seg_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (seg_q.size() == 0) begin
					$error("segment beat with no byte pending: tdata %h tlast %b",
						m_tdata, m_tlast);
					fails++;
				end else begin
					want = seg_q.pop_front();
					if (m_tdata[0] !== want.level) begin
						$error("pin_level: expected %0d, actual %0d", want.level, m_tdata[0]);
						fails++;
					end
					if (m_tdata[1] !== want.led) begin
						$error("led_id: expected %0d, actual %0d", want.led, m_tdata[1]);
						fails++;
					end
					if (m_tdata[23:2] !== want.dur) begin
						$error("duration_us: expected %0d, actual %0d", want.dur, m_tdata[23:2]);
						fails++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, m_tlast);
						fails++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PERIOD: begin
						period = pwdata[PERIOD_W-1:0];
					end
					REG_DEFAULT_ON: begin
						default_on   = pwdata[0];
						pin[led_sel] = ~pwdata[0];
					end
					REG_LED_SELECT: begin
						led_sel = pwdata[0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				encode_byte(s_tdata, s_tuser, s_tlast);
		end
		pending = seg_q.size();
	end

endmodule

FILE: bench/optical_pwm_manchester_tx_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical PWM / Manchester transmitter testbench
// Drives bytes in both encodings, with and without end of message, through
// a range of periods, idle levels and LED selections, under varying source
// gaps and sink stalls. The checker beside the block judges every segment.
// ----------------------------------------------------------------------------
module optical_pwm_manchester_tx_top_test;
	import opmt_pkg::*;

	localparam logic [3:0] ADDR_PERIOD     = {REG_PERIOD, 2'b00};
	localparam logic [3:0] ADDR_DEFAULT_ON = {REG_DEFAULT_ON, 2'b00};
	localparam logic [3:0] ADDR_LED_SELECT = {REG_LED_SELECT, 2'b00};
	localparam logic [3:0] ADDR_SPARE      = 4'hC;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] mode
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // [0] pin_level, [1] led_id, [23:2] duration_us
	logic        m_tlast;
	int          fails;
	int          pending;
	int          send_idle_pct;
	int          stall_pct;

	always #6 clk = ~clk;

	optical_pwm_manchester_tx_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	optical_pwm_manchester_tx_check u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fails(fails), .pending(pending)
	);

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] data, input logic mode, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= mode;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_segments();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic program_setting();
		logic [31:0] v;
		int          pick;
		pick = $urandom_range(7);
		case (pick)
			0: v = 32'd0;
			1: v = 32'd1;
			2: v = 32'd4000000;
			3: v = 32'h003F_FFFF;
			4, 5: v = $urandom_range(4000000, 1);
			default: v = $urandom_range(200, 1);
		endcase
		if ($urandom_range(3) == 0)
			v[31:22] = 10'($urandom());
		apb_write(ADDR_PERIOD, v);
		v = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1);
		apb_write(ADDR_LED_SELECT, v);
		if ($urandom_range(9) < 7) begin
			v = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1);
			apb_write(ADDR_DEFAULT_ON, v);
		end
		if ($urandom_range(7) == 0)
			apb_write(ADDR_SPARE, $urandom());
	endtask

	task automatic send_messages(input int count);
		int   sent;
		int   len;
		int   k;
		logic md;
		logic eom_on;
		sent = 0;
		while (sent < count) begin
			len    = $urandom_range(5, 1);
			md     = 1'($urandom_range(1));
			eom_on = ($urandom_range(99) < 85);
			for (k = 0; k < len && sent < count; k++) begin
				if ($urandom_range(9) == 0)
					md = ~md;
				send_byte(8'($urandom_range(255)), md, eom_on && (k == len - 1));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = MODE_PULSE;
		s_tlast       = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_byte(8'h00, MODE_PULSE, 1'b0);
		send_byte(8'hFF, MODE_PULSE, 1'b1);
		send_byte(8'h00, MODE_MANCHESTER, 1'b0);
		send_byte(8'hFF, MODE_MANCHESTER, 1'b1);
		send_byte(8'hA5, MODE_MANCHESTER, 1'b0);
		send_byte(8'h5A, MODE_PULSE, 1'b0);
		send_byte(8'h01, MODE_PULSE, 1'b1);
		drain_segments();
		apb_write(ADDR_LED_SELECT, 32'd0);
		send_byte(8'h80, MODE_PULSE, 1'b0);
		send_byte(8'h7E, MODE_MANCHESTER, 1'b1);
		drain_segments();
		apb_write(ADDR_DEFAULT_ON, 32'd1);
		send_byte(8'hC3, MODE_PULSE, 1'b1);
		send_byte(8'h3C, MODE_MANCHESTER, 1'b0);
		drain_segments();
		apb_write(ADDR_PERIOD, 32'd0);
		send_byte(8'hFF, MODE_PULSE, 1'b0);
		send_byte(8'h55, MODE_MANCHESTER, 1'b1);
		drain_segments();
		apb_write(ADDR_PERIOD, 32'd1);
		send_byte(8'hAA, MODE_PULSE, 1'b0);
		send_byte(8'h81, MODE_MANCHESTER, 1'b1);
		drain_segments();
		apb_write(ADDR_PERIOD, 32'hFFFF_FFFF);
		apb_write(ADDR_DEFAULT_ON, 32'hFFFF_FFFE);
		send_byte(8'h69, MODE_PULSE, 1'b1);
		send_byte(8'h96, MODE_MANCHESTER, 1'b0);
		drain_segments();
		apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
		send_byte(8'h0F, MODE_PULSE, 1'b1);
		drain_segments();
		apb_write(ADDR_PERIOD, 32'd4000000);
		apb_write(ADDR_LED_SELECT, 32'hFFFF_FFFF);
		send_byte(8'hF0, MODE_MANCHESTER, 1'b1);
		send_byte(8'h33, MODE_PULSE, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 83; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 83; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			for (int st = 0; st < 3; st++) begin
				drain_segments();
				program_setting();
				if (st == 1) begin
					send_messages(8);
					drain_segments();
					send_messages(8);
				end else begin
					send_messages(16);
				end
			end
		end

		drain_segments();
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
rtl/opmt_pkg.sv
rtl/opmt_front.sv
rtl/opmt_queue.sv
rtl/opmt_back.sv
rtl/optical_pwm_manchester_tx_top.sv
bench/optical_pwm_manchester_tx_check.sv
bench/optical_pwm_manchester_tx_top_test.sv
